[src/assert_macros.svh]
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/hrsf_pkg.sv]
// Types, constants and small helpers for the size formatter.
// No dependencies; used by the top level and its checker.
package hrsf_pkg;

  localparam int unsigned COUNT_W    = 63;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned PROD_W     = COUNT_W + 7;   // holds 100 * count
  localparam int unsigned HUND_W     = 17;            // hundredths, below 100000
  localparam int unsigned CONV_W     = HUND_W + 1;    // even, two bits per cycle
  localparam int unsigned BCD_DIGITS = 6;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CONV_CYCLES = CONV_W / 2;
  localparam int unsigned CONV_CNT_W = $clog2(CONV_CYCLES);
  localparam int unsigned UNIT_W     = 3;
  localparam int unsigned SMALL_W    = 10;            // counts below 1000

  localparam logic [COUNT_W-1:0] SMALL_LIMIT  = COUNT_W'(1000);
  localparam logic [PROD_W-1:0]  SCALED_LIMIT = PROD_W'(100000);
  localparam logic [HUND_W-1:0]  WHOLE_MIN    = HUND_W'(995);
  localparam logic [CONV_W-1:0]  ROUND_WHOLE  = CONV_W'(50);
  localparam logic [CONV_W-1:0]  ROUND_TENTH  = CONV_W'(5);
  localparam int unsigned        UNIT_SHIFT   = 10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'd49;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ADD_A = 6'b000010,
    ST_ADD_B = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_CONV  = 6'b010000,
    ST_FMT   = 6'b100000
  } state_t;

  function automatic logic [CHAR_W-1:0] unit_letter(input logic [UNIT_W-1:0] k);
    logic [CHAR_W-1:0] c;
    case (k)
      3'd0:    c = 8'd66;  // B
      3'd1:    c = 8'd75;  // K
      3'd2:    c = 8'd77;  // M
      3'd3:    c = 8'd71;  // G
      3'd4:    c = 8'd84;  // T
      3'd5:    c = 8'd80;  // P
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // double-dabble digit correction
  function automatic logic [3:0] dabble_fix(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return CH_ZERO + {4'b0000, d};
  endfunction

endpackage

[src/human_readable_size_formatter.sv]
// Byte count to four-character size string (e.g. " 12K", "3.4M", "  0B").
// Depends on hrsf_pkg.
//
// Sequence: counts below 1000 go straight to the binary-to-BCD converter;
//   larger counts first form 100*count, then scale by unit step k (1..6).
// Throughput: a new word is taken only while idle, at the earliest at the
//   edge that ends the strobe cycle. The time is set by the scale loop (one
//   10-bit shift per cycle) and the binary-to-BCD converter (two bits per
//   cycle).
// Reset: synchronous active-low rst_n returns to idle and drops the strobe.
// The receiver cannot stall: each result is shown for one cycle only.
module human_readable_size_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hrsf_pkg::COUNT_W-1:0]  in_byte_count,
  output logic                          out_valid,
  output logic [hrsf_pkg::CHAR_W-1:0]   out_char_first,
  output logic [hrsf_pkg::CHAR_W-1:0]   out_char_second,
  output logic [hrsf_pkg::CHAR_W-1:0]   out_char_third,
  output logic [hrsf_pkg::CHAR_W-1:0]   out_unit_char
);
  import hrsf_pkg::*;

  // control
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // datapath
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;      // 100*count, then scaled down
  logic [UNIT_W-1:0]     unit_r, unit_nxt;      // unit step k
  logic                  small_r, small_nxt;    // count below 1000
  logic                  whole_r, whole_nxt;    // value at least 9.95
  logic [CONV_W-1:0]     conv_x_r, conv_x_nxt;  // binary bits still to shift in
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CONV_CNT_W-1:0] conv_cnt_r, conv_cnt_nxt;
  logic [CHAR_W-1:0]     first_r, first_nxt;
  logic [CHAR_W-1:0]     second_r, second_nxt;
  logic [CHAR_W-1:0]     third_r, third_nxt;
  logic [CHAR_W-1:0]     unit_ch_r, unit_ch_nxt;

  // shared adder and converter step
  logic [PROD_W-1:0]     add_operand;
  logic [PROD_W-1:0]     add_sum;
  logic [BCD_W-1:0]      dab_bcd;
  logic [CONV_W-1:0]     dab_x;
  logic [HUND_W-1:0]     hund;
  logic                  hund_whole;
  logic [3:0]            dg [BCD_DIGITS];
  logic                  carry_unit;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_char_first  = first_r;
  assign out_char_second = second_r;
  assign out_char_third  = third_r;
  assign out_unit_char   = unit_ch_r;

  // 100*n = (n<<2) + (n<<5) + (n<<6): loaded with n<<2, then two adds
  assign add_operand = (state_r == ST_ADD_A) ? PROD_W'({count_r, 5'b0})
                                              : PROD_W'({count_r, 6'b0});
  assign add_sum = prod_r + add_operand;

  // two double-dabble steps per cycle
  always_comb begin
    logic [BCD_W-1:0]  b;
    logic [CONV_W-1:0] x;
    b = bcd_r;
    x = conv_x_r;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        b[i*4 +: 4] = dabble_fix(b[i*4 +: 4]);
      end
      b = {b[BCD_W-2:0], x[CONV_W-1]};
      x = {x[CONV_W-2:0], 1'b0};
    end
    dab_bcd = b;
    dab_x   = x;
  end

  // once scaled below 1000.00, prod holds the truncated hundredths
  assign hund       = prod_r[HUND_W-1:0];
  assign hund_whole = (hund >= WHOLE_MIN);

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dg[i] = bcd_r[i*4 +: 4];
    end
  end

  // rounded whole value of 999 or more rolls to "1.0" of the next unit
  assign carry_unit = (dg[5] != 4'd0) ||
                      ((dg[4] == 4'd9) && (dg[3] == 4'd9) && (dg[2] == 4'd9));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    count_nxt     = count_r;
    prod_nxt      = prod_r;
    unit_nxt      = unit_r;
    small_nxt     = small_r;
    whole_nxt     = whole_r;
    conv_x_nxt    = conv_x_r;
    bcd_nxt       = bcd_r;
    conv_cnt_nxt  = conv_cnt_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    third_nxt     = third_r;
    unit_ch_nxt   = unit_ch_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          count_nxt    = in_byte_count;
          prod_nxt     = PROD_W'({in_byte_count, 2'b0});
          unit_nxt     = '0;
          whole_nxt    = 1'b0;
          bcd_nxt      = '0;
          conv_cnt_nxt = '0;
          conv_x_nxt   = CONV_W'(in_byte_count[SMALL_W-1:0]);
          if (in_byte_count < SMALL_LIMIT) begin
            small_nxt = 1'b1;
            state_nxt = ST_CONV;
          end else begin
            small_nxt = 1'b0;
            state_nxt = ST_ADD_A;
          end
        end
      end
      ST_ADD_A: begin
        prod_nxt  = add_sum;
        state_nxt = ST_ADD_B;
      end
      ST_ADD_B: begin
        prod_nxt  = add_sum;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        // floor(100n/2^s) >= 100000 exactly when floor(n/2^s) >= 1000
        if (prod_r >= SCALED_LIMIT) begin
          prod_nxt = prod_r >> UNIT_SHIFT;
          unit_nxt = unit_r + UNIT_W'(1);
        end else begin
          whole_nxt  = hund_whole;
          conv_x_nxt = hund_whole ? ({1'b0, hund} + ROUND_WHOLE)
                                  : ({1'b0, hund} + ROUND_TENTH);
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt      = dab_bcd;
        conv_x_nxt   = dab_x;
        conv_cnt_nxt = conv_cnt_r + CONV_CNT_W'(1);
        if (conv_cnt_r == CONV_CNT_W'(CONV_CYCLES - 1)) begin
          state_nxt = ST_FMT;
        end
      end
      ST_FMT: begin
        if (small_r) begin
          first_nxt   = (dg[2] != 4'd0) ? digit_char(dg[2]) : CH_SPACE;
          second_nxt  = ((dg[2] != 4'd0) || (dg[1] != 4'd0)) ? digit_char(dg[1])
                                                             : CH_SPACE;
          third_nxt   = digit_char(dg[0]);
          unit_ch_nxt = unit_letter(unit_r);
        end else if (whole_r) begin
          // digits 5..2 hold round(h/100)
          if (carry_unit) begin
            first_nxt   = CH_ONE;
            second_nxt  = CH_DOT;
            third_nxt   = CH_ZERO;
            unit_ch_nxt = unit_letter(unit_r + UNIT_W'(1));
          end else begin
            first_nxt   = (dg[4] != 4'd0) ? digit_char(dg[4]) : CH_SPACE;
            second_nxt  = digit_char(dg[3]);
            third_nxt   = digit_char(dg[2]);
            unit_ch_nxt = unit_letter(unit_r);
          end
        end else begin
          // digits 2..1 hold round(h/10), at most 99
          first_nxt   = digit_char(dg[2]);
          second_nxt  = CH_DOT;
          third_nxt   = digit_char(dg[1]);
          unit_ch_nxt = unit_letter(unit_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    prod_r     <= prod_nxt;
    unit_r     <= unit_nxt;
    small_r    <= small_nxt;
    whole_r    <= whole_nxt;
    conv_x_r   <= conv_x_nxt;
    bcd_r      <= bcd_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    third_r    <= third_nxt;
    unit_ch_r  <= unit_ch_nxt;
  end

endmodule

[src/hrsf_checker.sv]
// Port-level checker for the size formatter, bound to the top level.
// Depends on hrsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrsf_assert_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [hrsf_pkg::CHAR_W-1:0]  out_char_third
);
  import hrsf_pkg::*;

  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "reset must idle the block")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word must raise busy")
  `ASSERT_CLK(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `ASSERT_CLK(a_no_strobe_busy, busy |-> !out_valid, "result shown while still working")
  `ASSERT_CLK(a_third_digit, out_valid |-> (out_char_third >= CH_ZERO && out_char_third <= CH_NINE), "third character is not a digit")

endmodule

bind human_readable_size_formatter hrsf_assert_checker u_hrsf_checker (.*);
